// ----- sv/prr_pkg.sv -----
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants for permutation rank/unrank
// Beat layouts, the pipeline work word and the factorial table.
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int NUM_ELEMENTS = 9;
  localparam int NIB_W        = 4;
  localparam int PERM_W       = 36;
  localparam int RANK_W       = 19;
  localparam int POS_W        = 4;
  localparam int CNT_W        = 4;
  localparam int PROD_W       = RANK_W + CNT_W;
  localparam int IDX_W        = 6;

  localparam logic OP_RANK   = 1'b0;
  localparam logic OP_UNRANK = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [PERM_W-1:0] perm_in;
    logic [RANK_W-1:0] rank_in;
  } req_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_out;
    logic [PERM_W-1:0] perm_out;
    logic              range_error;
  } rsp_t;

  typedef struct packed {
    logic                    opcode;
    logic                    err;
    logic [PERM_W-1:0]       perm;
    logic [RANK_W-1:0]       sum;
    logic [RANK_W-1:0]       rem;
    logic [NUM_ELEMENTS-1:0] used;
    logic [PERM_W-1:0]       packed_perm;
  } work_t;

  function automatic logic [RANK_W-1:0] fact(input logic [POS_W:0] k);
    logic [RANK_W-1:0] f;
    case (k)
      5'd0:    f = 19'd1;
      5'd1:    f = 19'd1;
      5'd2:    f = 19'd2;
      5'd3:    f = 19'd6;
      5'd4:    f = 19'd24;
      5'd5:    f = 19'd120;
      5'd6:    f = 19'd720;
      5'd7:    f = 19'd5040;
      5'd8:    f = 19'd40320;
      5'd9:    f = 19'd362880;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ----- sv/prr_stage.sv -----
// ----------------------------------------------------------------------------
// prr_stage: one position of the rank/unrank pipeline
// Adds the weighted smaller-later count for rank and picks the next unused
// element by factorial quotient for unrank, then registers the work word.
// ----------------------------------------------------------------------------
module prr_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [prr_pkg::POS_W-1:0]     pos,
  input  logic                          up_valid,
  input  prr_pkg::work_t                up_data,
  output logic                          up_ready,
  output logic                          dn_valid,
  output prr_pkg::work_t                dn_data,
  input  logic                          dn_ready
);

  prr_pkg::work_t                       data_next;
  logic [prr_pkg::IDX_W-1:0]            idx;
  logic [prr_pkg::NIB_W-1:0]            here;
  logic [prr_pkg::CNT_W-1:0]            cnt;
  logic [prr_pkg::RANK_W-1:0]           w;
  logic [prr_pkg::PROD_W-1:0]           prod;
  logic [prr_pkg::PROD_W-1:0]           pick_w;
  logic [prr_pkg::PROD_W-1:0]           rem_ext;
  logic [prr_pkg::CNT_W-1:0]            pick;
  logic [prr_pkg::CNT_W-1:0]            seen;
  logic [prr_pkg::POS_W-1:0]            chosen;
  logic                                 done;
  logic [prr_pkg::NUM_ELEMENTS-1:0]     unused;

  assign up_ready = !dn_valid || dn_ready;
  assign idx      = {2'b00, pos} << 2;
  assign here     = up_data.perm[idx +: prr_pkg::NIB_W];
  assign w        = prr_pkg::fact({1'b0, prr_pkg::POS_W'(prr_pkg::NUM_ELEMENTS - 1)} -
                                  {1'b0, pos});
  assign rem_ext  = prr_pkg::PROD_W'(up_data.rem);
  assign unused   = ~up_data.used;

  always_comb begin
    cnt = '0;
    for (int j = 0; j < prr_pkg::NUM_ELEMENTS; j++) begin
      if (prr_pkg::POS_W'(j) > pos &&
          up_data.perm[j*prr_pkg::NIB_W +: prr_pkg::NIB_W] < here) begin
        cnt = cnt + 1'b1;
      end
    end
  end

  assign prod = prr_pkg::PROD_W'(cnt) * prr_pkg::PROD_W'(w);

  always_comb begin
    pick = '0;
    for (int k = 1; k < prr_pkg::NUM_ELEMENTS; k++) begin
      if (rem_ext >= prr_pkg::PROD_W'(k) * prr_pkg::PROD_W'(w)) begin
        pick = pick + 1'b1;
      end
    end
  end

  assign pick_w = prr_pkg::PROD_W'(pick) * prr_pkg::PROD_W'(w);

  always_comb begin
    chosen = '0;
    seen   = '0;
    done   = 1'b0;
    for (int e = 0; e < prr_pkg::NUM_ELEMENTS; e++) begin
      if (!done && unused[e]) begin
        chosen = prr_pkg::POS_W'(e);
        if (seen == pick) begin
          done = 1'b1;
        end else begin
          seen = seen + 1'b1;
        end
      end
    end
  end

  always_comb begin
    data_next      = up_data;
    data_next.sum  = up_data.sum + prod[prr_pkg::RANK_W-1:0];
    data_next.rem  = up_data.rem - pick_w[prr_pkg::RANK_W-1:0];
    data_next.used = up_data.used |
                     (prr_pkg::NUM_ELEMENTS'(1) << chosen);
    data_next.packed_perm[idx +: prr_pkg::NIB_W] = prr_pkg::NIB_W'(chosen);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

// ----- sv/prr_out.sv -----
// ----------------------------------------------------------------------------
// prr_out: result register
// Selects the fields that the opcode keeps and holds the response beat.
// ----------------------------------------------------------------------------
module prr_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  prr_pkg::work_t  up_data,
  output logic            up_ready,
  output logic            rsp_valid,
  output prr_pkg::rsp_t   rsp_data,
  input  logic            rsp_stall
);

  prr_pkg::rsp_t rsp_next;
  logic          is_unrank;

  assign up_ready  = !rsp_valid || !rsp_stall;
  assign is_unrank = (up_data.opcode == prr_pkg::OP_UNRANK);

  always_comb begin
    rsp_next.rank_out    = is_unrank ? '0 : up_data.sum;
    rsp_next.perm_out    = (is_unrank && !up_data.err) ? up_data.packed_perm : '0;
    rsp_next.range_error = is_unrank && up_data.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (up_ready) begin
      rsp_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

// ----- sv/permutation_rank_unrank_top.sv -----
// ----------------------------------------------------------------------------
// permutation_rank_unrank_top: Lehmer code rank and unrank of 9 elements
// Converts a packed permutation to its lexicographic rank, or a rank back
// to the packed permutation, one request beat in and one response beat out.
//
// Request channel: req_valid, req_stall, req_data. A beat is taken on a
// rising edge with req_valid high and req_stall low. Response channel:
// rsp_valid, rsp_stall, rsp_data, taken the same way.
// The path has one register stage for each of the 9 positions, then the
// response register. Throughput is one beat per cycle while rsp_stall is
// low; the position stages are the pipeline that sets that figure.
// An unrank of a rank of 9! or more returns range_error with zero payload.
// Reset (rst, synchronous) empties every stage. While rsp_stall is high the
// response holds, and stages fill toward it; req_stall rises only once the
// stage behind the request port is full and cannot advance.
// ----------------------------------------------------------------------------
module permutation_rank_unrank_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  prr_pkg::req_t  req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output prr_pkg::rsp_t  rsp_data
);

  logic           vld [0:prr_pkg::NUM_ELEMENTS];
  logic           rdy [0:prr_pkg::NUM_ELEMENTS];
  prr_pkg::work_t dat [0:prr_pkg::NUM_ELEMENTS];

  always_comb begin
    dat[0]             = '0;
    dat[0].opcode      = req_data.opcode;
    dat[0].perm        = req_data.perm_in;
    dat[0].rem         = req_data.rank_in;
    dat[0].err         = (req_data.rank_in >=
                          prr_pkg::fact((prr_pkg::POS_W + 1)'(prr_pkg::NUM_ELEMENTS)));
  end

  assign vld[0]    = req_valid;
  assign req_stall = !rdy[0];

  for (genvar i = 0; i < prr_pkg::NUM_ELEMENTS; i++) begin : g_stage
    prr_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .pos      (prr_pkg::POS_W'(i)),
      .up_valid (vld[i]),
      .up_data  (dat[i]),
      .up_ready (rdy[i]),
      .dn_valid (vld[i+1]),
      .dn_data  (dat[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

  prr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (vld[prr_pkg::NUM_ELEMENTS]),
    .up_data   (dat[prr_pkg::NUM_ELEMENTS]),
    .up_ready  (rdy[prr_pkg::NUM_ELEMENTS]),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data),
    .rsp_stall (rsp_stall)
  );

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for permutation_rank_unrank_top
// Drives rank and unrank beats with bursty valid and a patterned response
// stall. Every response beat is checked against a Lehmer code conversion
// computed here: directed corner beats first, then random permutations,
// malformed nibble patterns and ranks on both sides of 9!.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD   = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 30;
  localparam int RANDOM_BEATS = 1500;

  class lehmer_scoreboard;
    prr_pkg::rsp_t pending_conversions[$];
    int            bad_beats;

    function new();
      bad_beats = 0;
    endfunction

    function logic [31:0] factorial_of(int k);
      logic [31:0] f;
      f = 1;
      for (int i = 2; i <= k; i++) f = f * i;
      return f;
    endfunction

    function logic [prr_pkg::RANK_W-1:0] perm_to_rank(logic [prr_pkg::PERM_W-1:0] p);
      logic [31:0] total;
      logic [3:0]  here;
      int          smaller;
      total = 0;
      for (int i = 0; i < prr_pkg::NUM_ELEMENTS; i++) begin
        here = p[i*prr_pkg::NIB_W +: prr_pkg::NIB_W];
        smaller = 0;
        for (int j = i + 1; j < prr_pkg::NUM_ELEMENTS; j++) begin
          if (p[j*prr_pkg::NIB_W +: prr_pkg::NIB_W] < here) smaller++;
        end
        total = total + smaller * factorial_of(prr_pkg::NUM_ELEMENTS - 1 - i);
      end
      return total[prr_pkg::RANK_W-1:0];
    endfunction

    function logic [prr_pkg::PERM_W-1:0] rank_to_perm(logic [prr_pkg::RANK_W-1:0] r);
      logic [31:0]                      left;
      logic [31:0]                      weight;
      logic [31:0]                      pick;
      logic [prr_pkg::NUM_ELEMENTS-1:0] taken;
      logic [prr_pkg::PERM_W-1:0]       p;
      logic [31:0]                      seen;
      int                               chosen;
      bit                               found;
      left  = 32'(r);
      taken = '0;
      p     = '0;
      for (int i = 0; i < prr_pkg::NUM_ELEMENTS; i++) begin
        weight = factorial_of(prr_pkg::NUM_ELEMENTS - 1 - i);
        pick   = left / weight;
        left   = left % weight;
        seen   = 0;
        chosen = 0;
        found  = 0;
        for (int e = 0; e < prr_pkg::NUM_ELEMENTS; e++) begin
          if (!taken[e] && !found) begin
            chosen = e;
            if (seen == pick) found = 1;
            else seen++;
          end
        end
        taken[chosen] = 1'b1;
        p[i*prr_pkg::NIB_W +: prr_pkg::NIB_W] = chosen[3:0];
      end
      return p;
    endfunction

    function prr_pkg::rsp_t convert(prr_pkg::req_t r);
      prr_pkg::rsp_t x;
      x = '0;
      if (r.opcode == prr_pkg::OP_RANK) begin
        x.rank_out = perm_to_rank(r.perm_in);
      end else if (r.rank_in >= factorial_of(prr_pkg::NUM_ELEMENTS)) begin
        x.range_error = 1'b1;
      end else begin
        x.perm_out = rank_to_perm(r.rank_in);
      end
      return x;
    endfunction

    function void note_request(prr_pkg::req_t r);
      pending_conversions = {pending_conversions, convert(r)};
    endfunction

    function void check_response(prr_pkg::rsp_t got);
      prr_pkg::rsp_t want;
      if (pending_conversions.size() == 0) begin
        $display("%0t: response beat with none outstanding: %h", $time, got);
        bad_beats++;
      end else begin
        want = pending_conversions.pop_front();
        if (got.rank_out !== want.rank_out) begin
          $display("%0t: rank_out expected %0d actual %0d", $time, want.rank_out,
                   got.rank_out);
          bad_beats++;
        end
        if (got.perm_out !== want.perm_out) begin
          $display("%0t: perm_out expected %h actual %h", $time, want.perm_out,
                   got.perm_out);
          bad_beats++;
        end
        if (got.range_error !== want.range_error) begin
          $display("%0t: range_error expected %b actual %b", $time, want.range_error,
                   got.range_error);
          bad_beats++;
        end
      end
    endfunction

    function int outstanding();
      return pending_conversions.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  prr_pkg::req_t req_data = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  prr_pkg::rsp_t rsp_data;

  lehmer_scoreboard sb;
  bit hold_off_req = 0;
  int burst_left = 0;

  permutation_rank_unrank_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req_data);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int stall_left;
    int stall_mode;
    stall_left = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(1, 60);
        end
        stall_left--;
        case (stall_mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 3) == 0);
          2: rsp_stall <= 1'($urandom_range(0, 1));
          default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic prr_pkg::req_t make_req(logic op,
                                             logic [prr_pkg::PERM_W-1:0] p,
                                             logic [prr_pkg::RANK_W-1:0] r);
    prr_pkg::req_t x;
    x.opcode  = op;
    x.perm_in = p;
    x.rank_in = r;
    return x;
  endfunction

  function automatic logic [prr_pkg::PERM_W-1:0] noise_perm();
    logic [63:0] x;
    x = {$urandom(), $urandom()};
    return x[prr_pkg::PERM_W-1:0];
  endfunction

  function automatic logic [prr_pkg::PERM_W-1:0] shuffled_perm();
    logic [3:0]                 v [prr_pkg::NUM_ELEMENTS];
    logic [3:0]                 t;
    logic [prr_pkg::PERM_W-1:0] p;
    int                         k;
    for (int i = 0; i < prr_pkg::NUM_ELEMENTS; i++) v[i] = 4'(i);
    for (int i = prr_pkg::NUM_ELEMENTS - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = v[i];
      v[i] = v[k];
      v[k] = t;
    end
    p = '0;
    for (int i = 0; i < prr_pkg::NUM_ELEMENTS; i++) p[i*prr_pkg::NIB_W +: prr_pkg::NIB_W] = v[i];
    return p;
  endfunction

  function automatic logic [prr_pkg::PERM_W-1:0] repeated_perm();
    logic [prr_pkg::PERM_W-1:0] p;
    p = '0;
    for (int i = 0; i < prr_pkg::NUM_ELEMENTS; i++) begin
      p[i*prr_pkg::NIB_W +: prr_pkg::NIB_W] = 4'($urandom_range(0, 8));
    end
    return p;
  endfunction

  function automatic logic [prr_pkg::RANK_W-1:0] noise_rank();
    logic [31:0] x;
    x = $urandom();
    return x[prr_pkg::RANK_W-1:0];
  endfunction

  task automatic send_beat(input prr_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic send_random_beat();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      send_beat(make_req(prr_pkg::OP_RANK, shuffled_perm(), noise_rank()));
    end else if (sel < 50) begin
      send_beat(make_req(prr_pkg::OP_RANK, noise_perm(), noise_rank()));
    end else if (sel < 55) begin
      send_beat(make_req(prr_pkg::OP_RANK, repeated_perm(), noise_rank()));
    end else if (sel < 88) begin
      send_beat(make_req(prr_pkg::OP_UNRANK, noise_perm(),
                         prr_pkg::RANK_W'($urandom_range(0, 362879))));
    end else if (sel < 92) begin
      send_beat(make_req(prr_pkg::OP_UNRANK, noise_perm(),
                         prr_pkg::RANK_W'($urandom_range(362870, 362890))));
    end else begin
      send_beat(make_req(prr_pkg::OP_UNRANK, noise_perm(), noise_rank()));
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_beat(make_req(prr_pkg::OP_RANK, 36'h876543210, '0));
    send_beat(make_req(prr_pkg::OP_RANK, 36'h012345678, '1));
    send_beat(make_req(prr_pkg::OP_RANK, 36'h786543210, 19'h2AAAA));
    send_beat(make_req(prr_pkg::OP_RANK, 36'h087654321, 19'h55555));
    send_beat(make_req(prr_pkg::OP_RANK, 36'h000000000, '0));
    send_beat(make_req(prr_pkg::OP_RANK, 36'hFFFFFFFFF, '1));
    send_beat(make_req(prr_pkg::OP_RANK, 36'h123456789, '0));
    send_beat(make_req(prr_pkg::OP_RANK, 36'h0F0F0F0F0, '0));
    send_beat(make_req(prr_pkg::OP_RANK, 36'hF0F0F0F0F, '1));
    send_beat(make_req(prr_pkg::OP_RANK, 36'h444444444, '0));
    send_beat(make_req(prr_pkg::OP_RANK, 36'hEDCBA9876, '0));
    send_beat(make_req(prr_pkg::OP_UNRANK, '1, 19'd0));
    send_beat(make_req(prr_pkg::OP_UNRANK, '0, 19'd1));
    send_beat(make_req(prr_pkg::OP_UNRANK, '1, 19'd40320));
    send_beat(make_req(prr_pkg::OP_UNRANK, '0, 19'd181440));
    send_beat(make_req(prr_pkg::OP_UNRANK, '1, 19'd362879));
    send_beat(make_req(prr_pkg::OP_UNRANK, '0, 19'd362880));
    send_beat(make_req(prr_pkg::OP_UNRANK, '1, 19'd362881));
    send_beat(make_req(prr_pkg::OP_UNRANK, '0, 19'h7FFFF));
    send_beat(make_req(prr_pkg::OP_UNRANK, '1, 19'h40000));
    drain();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 300) begin
        hold_off_req = 1;
        burst_left = 80;
      end
      if (n == 800) drain();
      send_random_beat();
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.bad_beats == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
